// ===== hw/rtl/sial_pkg.sv =====
// Package for the shift insert array list: sizes, operation and status codes,
// and the structs passed between the sequencer, the memory and the top level.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sial_pkg;

  // List geometry.
  localparam int unsigned Capacity = 128;
  localparam int unsigned ElemW    = 32;
  localparam int unsigned AddrW    = $clog2(Capacity);

  // Field widths of the request and response channels.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned PosW   = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 8;
  localparam int unsigned StatW  = 2;

  // Operation codes carried in the mode field.
  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_DELETE = 2'd1;
  localparam logic [ModeW-1:0] MODE_READ   = 2'd2;

  // Status codes returned with every response.
  localparam logic [StatW-1:0] STAT_DONE  = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_RANGE = 2'd2;

  // One access to the entry memory: an optional write and a read every cycle.
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ElemW-1:0] wdata;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic              valid;
    logic [ValueW-1:0] read_value;
    logic [CountW-1:0] entry_count;
    logic [StatW-1:0]  status;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sial_req_if.sv =====
// Request channel of the shift insert array list: valid, ready and payload.
// Depends on sial_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sial_req_if import sial_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ModeW-1:0]  mode;
  logic [PosW-1:0]   position;
  logic [ValueW-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/sial_rsp_if.sv =====
// Response channel of the shift insert array list: valid, ready and payload.
// Depends on sial_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sial_rsp_if import sial_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [ValueW-1:0] read_value;
  logic [CountW-1:0] entry_count;
  logic [StatW-1:0]  status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/sial_mem.sv =====
// Entry memory of the shift insert array list: one write port and one read
// port with registered read data. Depends on sial_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sial_mem import sial_pkg::*; (
  input  wire logic             clk_i,
  input  wire mem_req_t         req_i,
  output logic      [ElemW-1:0] rdata_o
);

  logic [ElemW-1:0] mem_q [Capacity];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port, data registered and available in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sial_seq.sv =====
// Sequencer of the shift insert array list: decodes a request, checks its
// range and steps one entry move per cycle through the memory.
// Depends on sial_pkg; drives sial_mem.
`timescale 1ns / 1ps
`default_nettype none

module sial_seq import sial_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ModeW-1:0]  mode_i,
  input  wire logic [PosW-1:0]   position_i,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic [ElemW-1:0]  rdata_i,
  output mem_req_t               mem_req_o,
  output logic                   idle_o,
  output result_t                res_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHIFT  = 3'd1;
  localparam logic [2:0] S_DRAIN  = 3'd2;
  localparam logic [2:0] S_PUT    = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic              wpend_q, wpend_d;
  logic [AddrW-1:0]  src_q, src_d;
  logic [AddrW-1:0]  end_q, end_d;
  logic [AddrW-1:0]  wdst_q, wdst_d;
  logic [ElemW-1:0]  val_q, val_d;
  logic [ModeW-1:0]  mode_q, mode_d;

  logic signed [PosW:0] pos_s;
  logic signed [PosW:0] cnt_s;
  logic                 ins_ok;
  logic                 pos_ok;
  logic [AddrW-1:0]     dest;
  logic [AddrW-1:0]     pos_a;
  logic [AddrW-1:0]     cnt_m1;
  logic [AddrW-1:0]     src_inc;
  logic [AddrW-1:0]     src_dec;
  logic                 is_ins;

  // Range checks on the incoming position against the current count.
  assign pos_s  = signed'({position_i[PosW-1], position_i});
  assign cnt_s  = signed'({1'b0, count_q});
  assign ins_ok = (pos_s >= -(PosW+1)'(1)) && (pos_s < cnt_s);
  assign pos_ok = (pos_s >= (PosW+1)'(0)) && (pos_s < cnt_s);
  assign pos_a  = position_i[AddrW-1:0];
  assign dest   = AddrW'(position_i + PosW'(1));
  assign cnt_m1 = AddrW'(count_q - CountW'(1));

  // Shared address step unit.
  assign src_inc = src_q + AddrW'(1);
  assign src_dec = src_q - AddrW'(1);
  assign is_ins  = (mode_q == MODE_INSERT);

  assign idle_o = (state_q == S_IDLE);

  // Next state, memory access and result.
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    wpend_d = wpend_q;
    src_d   = src_q;
    end_d   = end_q;
    wdst_d  = wdst_q;
    val_d   = val_q;
    mode_d  = mode_q;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = wdst_q;
    mem_req_o.wdata = rdata_i;
    mem_req_o.raddr = src_q;

    res_o.valid       = 1'b0;
    res_o.read_value  = '0;
    res_o.entry_count = count_q;
    res_o.status      = STAT_DONE;

    unique case (state_q)
      S_IDLE: begin
        mem_req_o.raddr = pos_a;
        if (start_i) begin
          mode_d  = mode_i;
          val_d   = ElemW'(value_i);
          wpend_d = 1'b0;
          unique case (mode_i)
            MODE_INSERT: begin
              if (count_q == CountW'(Capacity)) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_FULL;
              end else if (!ins_ok) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_RANGE;
              end else if ({1'b0, dest} == count_q) begin
                end_d   = dest;
                state_d = S_PUT;
              end else begin
                end_d   = dest;
                src_d   = cnt_m1;
                state_d = S_SHIFT;
              end
            end
            MODE_DELETE: begin
              if (!pos_ok) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_RANGE;
              end else if (pos_a == cnt_m1) begin
                count_d           = count_q - CountW'(1);
                res_o.valid       = 1'b1;
                res_o.entry_count = count_d;
              end else begin
                src_d   = pos_a + AddrW'(1);
                end_d   = cnt_m1;
                state_d = S_SHIFT;
              end
            end
            MODE_READ: begin
              if (!pos_ok) begin
                res_o.valid  = 1'b1;
                res_o.status = STAT_RANGE;
              end else begin
                state_d = S_RDWAIT;
              end
            end
            default: begin
              res_o.valid  = 1'b1;
              res_o.status = STAT_RANGE;
            end
          endcase
        end
      end
      // Read one entry per cycle and write back the entry read just before it.
      S_SHIFT: begin
        mem_req_o.we = wpend_q;
        wpend_d      = 1'b1;
        wdst_d       = is_ins ? src_inc : src_dec;
        if (src_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          src_d = is_ins ? src_dec : src_inc;
        end
      end
      // Write back the last entry read.
      S_DRAIN: begin
        mem_req_o.we = 1'b1;
        if (is_ins) begin
          state_d = S_PUT;
        end else begin
          count_d           = count_q - CountW'(1);
          res_o.valid       = 1'b1;
          res_o.entry_count = count_d;
          state_d           = S_IDLE;
        end
      end
      // Store the new value in the opened slot.
      S_PUT: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = end_q;
        mem_req_o.wdata   = val_q;
        count_d           = count_q + CountW'(1);
        res_o.valid       = 1'b1;
        res_o.entry_count = count_d;
        state_d           = S_IDLE;
      end
      S_RDWAIT: begin
        res_o.valid      = 1'b1;
        res_o.read_value = ValueW'(rdata_i);
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      wpend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      wpend_q <= wpend_d;
    end
  end

  // Operation payload and addresses.
  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    end_q  <= end_d;
    wdst_q <= wdst_d;
    val_q  <= val_d;
    mode_q <= mode_d;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/shift_insert_array_list.sv =====
// Shift insert array list: an ordered list of up to 128 words with insert,
// delete and read requests.
//
// A request on req_i carries a mode (insert after position, delete at
// position, read at position), a signed position (-1 means insert at the
// head) and a value. Each request yields one response on rsp_o with the read
// value, the entry count after the operation and a status.
//
// Timing: a request that fails its checks answers in the cycle after it is
// taken. A read waits in a state for the memory read data before its
// result is registered. An insert or delete moves each entry above the
// position once, one move per cycle through the single memory port pair.
// One request is in work at a time; req_i.ready is low until it finishes.
//
// Reset clears the entry count, so the list starts empty; the memory itself
// is not cleared. A response waits in the output register while the receiver
// stalls, and a new request is taken once that register is free or being
// emptied in the same cycle.
// Depends on sial_pkg, sial_req_if, sial_rsp_if, sial_mem and sial_seq.
`timescale 1ns / 1ps
`default_nettype none

module shift_insert_array_list import sial_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sial_req_if.sink  req_i,
  sial_rsp_if.source rsp_o
);

  mem_req_t         mem_req;
  logic [ElemW-1:0] rdata;
  logic             seq_idle;
  logic             start;
  result_t          res;

  logic              out_valid_q;
  logic [ValueW-1:0] out_value_q;
  logic [CountW-1:0] out_count_q;
  logic [StatW-1:0]  out_status_q;

  // Take a request when the sequencer is free and the output has room.
  assign req_i.ready = seq_idle && (!out_valid_q || rsp_o.ready);
  assign start       = req_i.valid && req_i.ready;

  sial_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .mode_i     (req_i.mode),
    .position_i (req_i.position),
    .value_i    (req_i.value),
    .rdata_i    (rdata),
    .mem_req_o  (mem_req),
    .idle_o     (seq_idle),
    .res_o      (res)
  );

  sial_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      out_value_q  <= res.read_value;
      out_count_q  <= res.entry_count;
      out_status_q <= res.status;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.read_value  = out_value_q;
  assign rsp_o.entry_count = out_count_q;
  assign rsp_o.status      = out_status_q;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for shift_insert_array_list: directed and random list
// operations, each checked against a behavioral list model kept in this file.
// Depends on sial_pkg, sial_req_if, sial_rsp_if and the shift_insert_array_list RTL.
`timescale 1ns / 1ps

module tb_top;
  import sial_pkg::*;

  // Mode 3 is not an operation; the block answers it with a range status.
  localparam logic [ModeW-1:0] ModeUnused = 2'd3;
  localparam int IdleLimit = 3000;
  localparam int HoldCycles = 400;
  localparam int DrainCycles = 200;

  // One response as the list model predicts it.
  typedef struct packed {
    logic [ValueW-1:0] rd_val;
    logic [CountW-1:0] cnt;
    logic [StatW-1:0]  st;
  } list_rsp_t;

  // One row of the directed table; typed rows carry their own answer.
  typedef struct packed {
    logic [ModeW-1:0]  m;
    logic [PosW-1:0]   p;
    logic [ValueW-1:0] v;
    logic              typed;
    list_rsp_t         want;
  } list_step_t;

  localparam int NumSteps = 23;

  list_step_t step_tbl [NumSteps] = '{
    // Empty list: nothing is in range, and insert only accepts the head.
    '{MODE_READ,   8'h00, 32'h0000_0000, 1'b1, '{32'h0, 8'd0, STAT_RANGE}},
    '{MODE_DELETE, 8'h00, 32'h0000_0000, 1'b1, '{32'h0, 8'd0, STAT_RANGE}},
    '{MODE_INSERT, 8'h00, 32'h0000_1234, 1'b1, '{32'h0, 8'd0, STAT_RANGE}},
    '{ModeUnused,  8'hFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'd0, STAT_RANGE}},
    '{MODE_INSERT, 8'hFF, 32'hFFFF_FFFF, 1'b1, '{32'h0, 8'd1, STAT_DONE}},
    // Insert positions outside -1 .. count-1.
    '{MODE_INSERT, 8'hFE, 32'h1111_1111, 1'b1, '{32'h0, 8'd1, STAT_RANGE}},
    '{MODE_INSERT, 8'h7F, 32'h2222_2222, 1'b1, '{32'h0, 8'd1, STAT_RANGE}},
    '{MODE_INSERT, 8'h80, 32'h3333_3333, 1'b1, '{32'h0, 8'd1, STAT_RANGE}},
    // Insert after the last entry appends at the tail.
    '{MODE_INSERT, 8'h00, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_DONE}},
    '{MODE_READ,   8'h00, 32'hDEAD_BEEF, 1'b1, '{32'hFFFF_FFFF, 8'd2, STAT_DONE}},
    '{MODE_READ,   8'h01, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_DONE}},
    '{MODE_READ,   8'hFF, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_RANGE}},
    '{MODE_DELETE, 8'h02, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_RANGE}},
    // Head and middle inserts, then reads and deletes that shift entries.
    '{MODE_INSERT, 8'hFF, 32'hA5A5_5A5A, 1'b0, '0},
    '{MODE_INSERT, 8'h01, 32'h0F0F_F0F0, 1'b0, '0},
    '{MODE_READ,   8'h00, 32'h0000_0000, 1'b0, '0},
    '{MODE_READ,   8'h02, 32'h0000_0000, 1'b0, '0},
    '{MODE_DELETE, 8'h01, 32'h0000_0000, 1'b0, '0},
    '{MODE_READ,   8'h01, 32'h0000_0000, 1'b0, '0},
    '{MODE_DELETE, 8'h00, 32'h0000_0000, 1'b0, '0},
    '{MODE_DELETE, 8'h80, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_RANGE}},
    '{MODE_READ,   8'h7F, 32'h0000_0000, 1'b1, '{32'h0, 8'd2, STAT_RANGE}},
    '{ModeUnused,  8'h00, 32'h5555_AAAA, 1'b0, '0}
  };

  logic clk_i;
  logic rst_ni;

  sial_req_if req_if ();
  sial_rsp_if rsp_if ();

  shift_insert_array_list dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // List model state.
  logic [ValueW-1:0] list_mem [Capacity];
  int                list_len;

  // Responses still owed by the block, oldest first.
  list_rsp_t owed_rsp [$];

  bit no_idle;
  bit hold_req;
  int errors;
  int n_sent;
  int n_checked;
  int n_full;
  int n_range;
  int peak_len;
  int idle_cycles;

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = ~clk_i;
  end

  // Apply one operation to the list model and return the response it owes.
  function automatic list_rsp_t apply_op(input logic [ModeW-1:0] m,
                                         input logic [PosW-1:0] p,
                                         input logic [ValueW-1:0] v);
    list_rsp_t r;
    int pos;
    pos = int'($signed(p));
    r = '0;
    r.st = STAT_DONE;
    case (m)
      MODE_INSERT: begin
        if (list_len >= int'(Capacity)) begin
          r.st = STAT_FULL;
        end else if (pos < -1 || pos > list_len - 1) begin
          r.st = STAT_RANGE;
        end else begin
          for (int i = list_len; i > pos + 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos+1] = v;
          list_len++;
        end
      end
      MODE_DELETE, MODE_READ: begin
        if (pos < 0 || pos >= list_len) begin
          r.st = STAT_RANGE;
        end else if (m == MODE_READ) begin
          r.rd_val = list_mem[pos];
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      default: begin
        r.st = STAT_RANGE;
      end
    endcase
    r.cnt = CountW'(list_len);
    return r;
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ValueW-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return $urandom;
  endfunction

  // Mostly a legal position for the current list, often at a boundary;
  // now and then any 8-bit pattern.
  function automatic logic [PosW-1:0] rand_pos(input logic [ModeW-1:0] m);
    int lo;
    int hi;
    int r;
    lo = (m == MODE_INSERT) ? -1 : 0;
    hi = list_len - 1;
    r = $urandom_range(0, 99);
    if (r < 12 || hi < lo) return PosW'($urandom);
    if (r < 22) return PosW'(lo);
    if (r < 32) return PosW'(hi);
    return PosW'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  // Offer one request, wait until it is taken, and record its response.
  task automatic send_req(input logic [ModeW-1:0] m, input logic [PosW-1:0] p,
                          input logic [ValueW-1:0] v, input logic typed,
                          input list_rsp_t want);
    int gap;
    list_rsp_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.mode     <= m;
    req_if.position <= p;
    req_if.value    <= v;
    do @(posedge clk_i); while (!req_if.ready);
    predicted = apply_op(m, p, v);
    owed_rsp.push_back(typed ? want : predicted);
    n_sent++;
    if (list_len > peak_len) peak_len = list_len;
  endtask

  task automatic run_random(input int n, input int ins_pct);
    logic [ModeW-1:0] m;
    int r;
    for (int k = 0; k < n; k++) begin
      if (k % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) m = ModeUnused;
      else if (r < 3 + ins_pct) m = MODE_INSERT;
      else if (r % 2 == 1) m = MODE_READ;
      else m = MODE_DELETE;
      send_req(m, rand_pos(m), rand_value(), 1'b0, '0);
    end
  endtask

  // Response receiver: random stalls, plus one long hold-off on request.
  initial begin : rsp_sink
    int n;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        rsp_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        rsp_if.ready <= 1'b0;
        n = pick_gap();
        repeat ((n > 0) ? n : 1) @(posedge clk_i);
      end
    end
  end

  // Compare each response with the oldest one owed; watch for a hang.
  always @(posedge clk_i) begin : rsp_check
    list_rsp_t want;
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_rsp.size() == 0) begin
          errors++;
          $display("%0t: response with none owed: value %h count %0d status %0d",
                   $time, rsp_if.read_value, rsp_if.entry_count, rsp_if.status);
        end else begin
          want = owed_rsp.pop_front();
          n_checked++;
          if (want.st == STAT_FULL) n_full++;
          if (want.st == STAT_RANGE) n_range++;
          if (rsp_if.read_value !== want.rd_val) begin
            errors++;
            $display("%0t: read_value expected %h, got %h", $time, want.rd_val,
                     rsp_if.read_value);
          end
          if (rsp_if.entry_count !== want.cnt) begin
            errors++;
            $display("%0t: entry_count expected %0d, got %0d", $time, want.cnt,
                     rsp_if.entry_count);
          end
          if (rsp_if.status !== want.st) begin
            errors++;
            $display("%0t: status expected %0d, got %0d", $time, want.st,
                     rsp_if.status);
          end
        end
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no request or response moved for %0d cycles", $time, IdleLimit);
        $display("tb_top failed");
        $finish;
      end
    end
  end

  // Stimulus: directed table, random mix, fill to full, drain to empty.
  initial begin : stim
    req_if.valid    = 1'b0;
    req_if.mode     = '0;
    req_if.position = '0;
    req_if.value    = '0;
    rsp_if.ready    = 1'b0;
    rst_ni          = 1'b0;
    no_idle         = 1'b0;
    hold_req        = 1'b0;
    errors          = 0;
    n_sent          = 0;
    n_checked       = 0;
    n_full          = 0;
    n_range         = 0;
    peak_len        = 0;
    idle_cycles     = 0;
    list_len        = 0;
    for (int i = 0; i < int'(Capacity); i++) list_mem[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumSteps; i++) begin
      send_req(step_tbl[i].m, step_tbl[i].p, step_tbl[i].v, step_tbl[i].typed,
               step_tbl[i].want);
    end

    run_random(30, 45);

    // Fill the list while the receiver holds off, so the block backs up.
    hold_req = 1'b1;
    while (list_len < int'(Capacity)) begin
      if ($urandom_range(0, 9) == 0) begin
        send_req(MODE_READ, rand_pos(MODE_READ), rand_value(), 1'b0, '0);
      end else begin
        send_req(MODE_INSERT, rand_pos(MODE_INSERT), rand_value(), 1'b0, '0);
      end
    end

    // Full list: full takes priority over a bad position; last slot works.
    send_req(MODE_INSERT, 8'hFF, rand_value(), 1'b0, '0);
    send_req(MODE_INSERT, 8'h80, rand_value(), 1'b0, '0);
    send_req(MODE_INSERT, 8'h7F, rand_value(), 1'b0, '0);
    send_req(MODE_READ,   8'h7F, rand_value(), 1'b0, '0);
    send_req(MODE_DELETE, 8'h7F, rand_value(), 1'b0, '0);
    send_req(MODE_READ,   8'h7F, rand_value(), 1'b0, '0);
    send_req(MODE_INSERT, 8'h7E, rand_value(), 1'b0, '0);
    send_req(MODE_READ,   8'h7F, rand_value(), 1'b0, '0);
    send_req(MODE_DELETE, 8'h00, rand_value(), 1'b0, '0);

    run_random(20, 50);

    // Drain to empty with deletes at random places.
    while (list_len > 0) begin
      if ($urandom_range(0, 99) < 85) begin
        send_req(MODE_DELETE, rand_pos(MODE_DELETE), rand_value(), 1'b0, '0);
      end else begin
        send_req(MODE_READ, rand_pos(MODE_READ), rand_value(), 1'b0, '0);
      end
    end

    run_random(30, 55);

    req_if.valid <= 1'b0;
    while (owed_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d responses (%0d list full, %0d range).",
             n_sent, n_checked, n_full, n_range);
    $display("The list reached %0d entries and was drained back to empty.", peak_len);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== shift_insert_array_list.f =====
hw/rtl/sial_pkg.sv
hw/rtl/sial_req_if.sv
hw/rtl/sial_rsp_if.sv
hw/rtl/sial_mem.sv
hw/rtl/sial_seq.sv
hw/rtl/shift_insert_array_list.sv
tb/tb_top.sv
